// ----- src/wkrt_pkg.sv -----
package wkrt_pkg;

  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_CHANGE = 3'd2;
  localparam logic [2:0] MODE_ROUTE  = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;
  localparam logic [2:0] MODE_FIND   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // datapath operations issued by the controller
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;  // capture item, start last-key read
  localparam logic [3:0] OP_SCAN_RD = 4'd2;  // read entry at ptr
  localparam logic [3:0] OP_SCAN_CK = 4'd3;  // compare read data, advance ptr
  localparam logic [3:0] OP_GAP_RD  = 4'd4;  // read ptr+1
  localparam logic [3:0] OP_GAP_WR  = 4'd5;  // write at ptr, advance
  localparam logic [3:0] OP_INS_RD  = 4'd6;  // read ptr-1
  localparam logic [3:0] OP_INS_CK  = 4'd7;  // shift up or place
  localparam logic [3:0] OP_DIV     = 4'd8;  // one modulo step
  localparam logic [3:0] OP_PREP    = 4'd9;  // set up insertion or gap close, or finish gap close
  localparam logic [3:0] OP_DONE    = 4'd10; // form result

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       hit;      // entry just read matches
    logic       scan_end; // ptr reached count
    logic       ins_stop; // insertion place found
    logic       gap_end;  // gap closed
    logic       div_end;  // modulo finished
    logic       full;
    logic       empty;    // count zero or last key zero
  } stat_t;

endpackage

// ----- src/wkrt_ctrl.sv -----
module wkrt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  wkrt_pkg::stat_t st,
  output wkrt_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_SRD    = 4'd3;
  localparam logic [3:0] S_SCK    = 4'd4;
  localparam logic [3:0] S_GRD    = 4'd5;
  localparam logic [3:0] S_GWR    = 4'd6;
  localparam logic [3:0] S_IRD    = 4'd7;
  localparam logic [3:0] S_ICK    = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_PREP   = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd.op = wkrt_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op = wkrt_pkg::OP_LOAD;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_DISP; // last-key read lands
      S_DISP: begin
        case (st.mode)
          wkrt_pkg::MODE_ADD: begin
            if (st.full) state_nxt = S_DONE;
            else begin
              cmd.op = wkrt_pkg::OP_PREP;
              state_nxt = S_IRD;
            end
          end
          wkrt_pkg::MODE_REMOVE, wkrt_pkg::MODE_CHANGE,
          wkrt_pkg::MODE_FIND: state_nxt = S_SRD;
          wkrt_pkg::MODE_ROUTE: state_nxt = st.empty ? S_DONE : S_DIV;
          wkrt_pkg::MODE_READ: begin
            cmd.op = wkrt_pkg::OP_SCAN_RD;
            state_nxt = S_SCK;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SRD: begin
        if (st.scan_end) state_nxt = S_DONE;
        else begin
          cmd.op = wkrt_pkg::OP_SCAN_RD;
          state_nxt = S_SCK;
        end
      end
      S_SCK: begin
        if (st.hit || st.mode == wkrt_pkg::MODE_READ) begin
          if (st.hit && (st.mode == wkrt_pkg::MODE_REMOVE ||
                         st.mode == wkrt_pkg::MODE_CHANGE)) begin
            cmd.op = wkrt_pkg::OP_PREP;
            state_nxt = S_GRD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cmd.op = wkrt_pkg::OP_SCAN_CK;
          state_nxt = S_SRD;
        end
      end
      S_GRD: begin
        if (st.gap_end) begin
          cmd.op = wkrt_pkg::OP_PREP;
          state_nxt = (st.mode == wkrt_pkg::MODE_CHANGE) ? S_IRD : S_DONE;
        end else begin
          cmd.op = wkrt_pkg::OP_GAP_RD;
          state_nxt = S_GWR;
        end
      end
      S_GWR: begin
        cmd.op = wkrt_pkg::OP_GAP_WR;
        state_nxt = S_GRD;
      end
      S_IRD: begin
        if (st.ins_stop) state_nxt = S_DONE;
        else begin
          cmd.op = wkrt_pkg::OP_INS_RD;
          state_nxt = S_ICK;
        end
      end
      S_ICK: begin
        cmd.op = wkrt_pkg::OP_INS_CK;
        state_nxt = S_IRD;
      end
      S_DIV: begin
        if (st.div_end) state_nxt = S_SRD;
        else cmd.op = wkrt_pkg::OP_DIV;
      end
      S_DONE: begin
        cmd.op = wkrt_pkg::OP_DONE;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ----- src/wkrt_datapath.sv -----
module wkrt_datapath #(
  parameter int DEPTH = 128
) (
  input  logic            clk,
  input  logic            rst_n,
  input  wkrt_pkg::cmd_t  cmd,
  output wkrt_pkg::stat_t st,
  input  logic [63:0]     in_tdata,
  output logic [71:0]     out_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0] key_mem [DEPTH];
  logic [15:0] dest_mem [DEPTH];
  logic [31:0] rd_key_r;
  logic [15:0] rd_dest_r;

  logic [2:0]  mode_r;
  logic [31:0] kv_r;
  logic [15:0] id_r;
  logic [6:0]  slot_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] ptr_r;
  logic [CW-1:0] n_r;      // upper bound for gap close
  logic [31:0] lastkey_r;
  logic [31:0] rem_r;
  logic [5:0]  dstep_r;
  logic [15:0] keep_r;
  logic        hit_r, istop_r;
  logic [AW-1:0] fpos_r;
  logic [31:0] fkey_r;
  logic [15:0] fdest_r;

  logic [1:0]  ostat_r;
  logic [15:0] odest_r;
  logic [31:0] okey_r;
  logic [6:0]  oslot_r;
  logic [7:0]  otot_r;

  logic            wr_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [31:0]     wr_key;
  logic [15:0]     wr_dest;
  logic [CW-1:0]   last_idx;
  logic            match;
  logic [32:0]     rem_sh;

  // flag: the previous cycle issued a scan read
  logic scan_chk_r;
  logic lk_chk_r;

  assign last_idx = cnt_r - CW'(1);

  always_comb begin
    rd_addr = ptr_r[AW-1:0];
    case (cmd.op)
      wkrt_pkg::OP_LOAD:   rd_addr = last_idx[AW-1:0];
      wkrt_pkg::OP_GAP_RD: rd_addr = AW'(ptr_r + CW'(1));
      wkrt_pkg::OP_INS_RD: rd_addr = AW'(ptr_r - CW'(1));
      default:             rd_addr = ptr_r[AW-1:0];
    endcase
  end

  // compare result for the scan
  always_comb begin
    case (mode_r)
      wkrt_pkg::MODE_ROUTE: match = rd_key_r > rem_r;
      wkrt_pkg::MODE_READ:  match = 32'(slot_r) < 32'(cnt_r) &&
                                    32'(slot_r) < 32'(DEPTH);
      default:              match = rd_dest_r == id_r;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = ptr_r[AW-1:0];
    wr_key = rd_key_r;
    wr_dest = rd_dest_r;
    if (cmd.op == wkrt_pkg::OP_GAP_WR) wr_en = 1'b1;
    if (cmd.op == wkrt_pkg::OP_INS_CK) begin
      wr_en = 1'b1;
      if (ptr_r == '0 || kv_r >= rd_key_r) begin
        wr_key = kv_r;
        wr_dest = keep_r;
      end else begin
        // shift up: ptr_r holds destination
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      dest_mem[wr_addr] <= wr_dest;
    end
    rd_key_r  <= key_mem[rd_addr];
    rd_dest_r <= dest_mem[rd_addr];
  end

  assign rem_sh = {rem_r, kv_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (cmd.op)
        wkrt_pkg::OP_LOAD: begin
          mode_r <= in_tdata[2:0];
          kv_r   <= in_tdata[34:3];
          id_r   <= in_tdata[50:35];
          slot_r <= in_tdata[57:51];
          ptr_r  <= (in_tdata[2:0] == wkrt_pkg::MODE_READ) ?
                    CW'(in_tdata[57:51]) : '0;
          hit_r  <= 1'b0;
          istop_r <= 1'b0;
          rem_r  <= '0;
          dstep_r <= '0;
        end
        wkrt_pkg::OP_SCAN_RD: hit_r <= 1'b0;
        wkrt_pkg::OP_SCAN_CK: ptr_r <= ptr_r + CW'(1);
        wkrt_pkg::OP_DIV: begin
          // restoring modulo, one bit per cycle
          kv_r <= {kv_r[30:0], 1'b0};
          if (rem_sh >= {1'b0, lastkey_r}) rem_r <= 32'(rem_sh - {1'b0, lastkey_r});
          else rem_r <= rem_sh[31:0];
          dstep_r <= dstep_r + 6'd1;
        end
        wkrt_pkg::OP_PREP: begin
          if (mode_r == wkrt_pkg::MODE_ADD) begin
            ptr_r  <= cnt_r;
            keep_r <= id_r;
            cnt_r  <= cnt_r + CW'(1);
            istop_r <= 1'b0;
          end else if (!hit_r) begin
            // entry found at ptr_r: latch it, start gap close
            fpos_r  <= ptr_r[AW-1:0];
            fkey_r  <= rd_key_r;
            fdest_r <= rd_dest_r;
            keep_r  <= rd_dest_r;
            hit_r   <= 1'b1;
            n_r     <= cnt_r;
          end else begin
            // gap closed; ptr_r = n_r-1
            if (mode_r == wkrt_pkg::MODE_REMOVE) cnt_r <= cnt_r - CW'(1);
            istop_r <= 1'b0;
          end
        end
        wkrt_pkg::OP_GAP_WR: ptr_r <= ptr_r + CW'(1);
        wkrt_pkg::OP_INS_CK: begin
          if (ptr_r == '0 || kv_r >= rd_key_r) begin
            istop_r <= 1'b1;
            fpos_r  <= ptr_r[AW-1:0];
          end else begin
            ptr_r <= ptr_r - CW'(1);
          end
        end
        wkrt_pkg::OP_DONE: begin
          ostat_r <= wkrt_pkg::ST_OK;
          odest_r <= '0;
          okey_r  <= '0;
          oslot_r <= '0;
          case (mode_r)
            wkrt_pkg::MODE_ADD, wkrt_pkg::MODE_CHANGE: begin
              if (mode_r == wkrt_pkg::MODE_ADD && !istop_r) begin
                ostat_r <= wkrt_pkg::ST_FULL;
              end else if (mode_r == wkrt_pkg::MODE_CHANGE && !hit_r) begin
                ostat_r <= wkrt_pkg::ST_MISS;
              end else begin
                odest_r <= keep_r;
                okey_r  <= kv_r;
                oslot_r <= 7'(fpos_r);
              end
            end
            wkrt_pkg::MODE_REMOVE: begin
              if (!hit_r) ostat_r <= wkrt_pkg::ST_MISS;
              else begin
                odest_r <= fdest_r;
                okey_r  <= fkey_r;
                oslot_r <= 7'(fpos_r);
              end
            end
            wkrt_pkg::MODE_ROUTE: begin
              if (st.empty) ostat_r <= wkrt_pkg::ST_EMPTY;
              else if (hit_r) begin
                odest_r <= rd_dest_r;
                okey_r  <= rd_key_r;
                oslot_r <= 7'(ptr_r);
              end else begin
                // last entry always satisfies key > rem
                odest_r <= rd_dest_r;
                okey_r  <= rd_key_r;
                oslot_r <= 7'(last_idx);
              end
            end
            wkrt_pkg::MODE_READ, wkrt_pkg::MODE_FIND: begin
              if (!hit_r) ostat_r <= wkrt_pkg::ST_MISS;
              else begin
                odest_r <= rd_dest_r;
                okey_r  <= rd_key_r;
                oslot_r <= 7'(ptr_r);
              end
            end
            default: ostat_r <= wkrt_pkg::ST_MISS;
          endcase
          otot_r <= 8'(cnt_r);
        end
        default: ;
      endcase
      // scan hit detection happens the cycle the read data is valid
      if (cmd.op == wkrt_pkg::OP_NONE && scan_chk_r) hit_r <= match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) scan_chk_r <= 1'b0;
    else scan_chk_r <= (cmd.op == wkrt_pkg::OP_SCAN_RD);
  end

  always_ff @(posedge clk) begin
    if (cmd.op == wkrt_pkg::OP_NONE && lk_chk_r) lastkey_r <= rd_key_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) lk_chk_r <= 1'b0;
    else lk_chk_r <= (cmd.op == wkrt_pkg::OP_LOAD);
  end

  always_comb begin
    st.mode     = mode_r;
    st.hit      = match;
    st.scan_end = ptr_r >= cnt_r;
    st.ins_stop = istop_r;
    st.gap_end  = (ptr_r + CW'(1)) >= n_r;
    st.div_end  = dstep_r == 6'd32;
    st.full     = cnt_r >= CW'(DEPTH);
    st.empty    = (cnt_r == '0) || (lastkey_r == '0);
  end

  assign out_tdata = {7'd0, otot_r, oslot_r, okey_r, odest_r, ostat_r};

endmodule

// ----- src/weighted_key_route_table_core.sv -----
// Work per item: read slot reads one entry; a full add, an empty route or an unused mode go
// straight to the result; find and remove scan the table, add shifts entries up to insert,
// route runs a bit-serial modulo and then scans, and change scans, closes the gap and
// inserts. One item is worked at a time; with out_tready high the next is accepted
// once the result has been taken and the block is back in idle.
// rst_n (synchronous, active low) empties the table; entries are not cleared.
module weighted_key_route_table_core #(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // mode, key_value, dest_id, slot_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // status, found_dest, found_key, found_slot, entry_total
);

  wkrt_pkg::cmd_t  cmd;
  wkrt_pkg::stat_t st;

  wkrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  wkrt_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

// ----- dv/weighted_key_route_table_core_test.sv -----
`timescale 1ns / 1ps

module weighted_key_route_table_core_test;

  localparam int TABLE_DEPTH = 128;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key_value;
    logic [15:0] dest_id;
    logic [6:0]  slot_index;
  } route_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_dest;
    logic [31:0] found_key;
    logic [6:0]  found_slot;
    logic [7:0]  entry_total;
  } route_rsp_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [63:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [71:0] out_tdata;

  weighted_key_route_table_core #(.DEPTH(TABLE_DEPTH)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // shadow table for prediction
  logic [31:0] tbl_key [TABLE_DEPTH];
  logic [15:0] tbl_dest [TABLE_DEPTH];
  int tbl_count;

  // stimulus-side shadow, to keep generated ids and slots meaningful
  logic [15:0] gen_ids [$];

  route_req_t pending_reqs [$];
  route_rsp_t expected_rsps [$];

  int  errors;
  int  idle_cycles;
  bit  stim_done;
  bit  calm;
  int  in_gap;
  int  out_gap;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] pack_req(route_req_t r);
    return {6'd0, r.slot_index, r.dest_id, r.key_value, r.mode};
  endfunction

  function automatic route_rsp_t unpack_rsp(logic [71:0] d);
    route_rsp_t r;
    r.status      = d[1:0];
    r.found_dest  = d[17:2];
    r.found_key   = d[49:18];
    r.found_slot  = d[56:50];
    r.entry_total = d[64:57];
    return r;
  endfunction

  function automatic int find_dest(logic [15:0] id);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_dest[i] == id) return i;
    return -1;
  endfunction

  function automatic int place_sorted(int n, logic [31:0] k, logic [15:0] id);
    int i;
    i = n;
    while (i > 0 && k < tbl_key[i-1]) begin
      tbl_key[i] = tbl_key[i-1];
      tbl_dest[i] = tbl_dest[i-1];
      i--;
    end
    tbl_key[i] = k;
    tbl_dest[i] = id;
    return i;
  endfunction

  function automatic void drop_entry(int p);
    for (int i = p; i + 1 < tbl_count; i++) begin
      tbl_key[i] = tbl_key[i+1];
      tbl_dest[i] = tbl_dest[i+1];
    end
  endfunction

  function automatic route_rsp_t predict_route(route_req_t r);
    route_rsp_t o;
    int p;
    logic [31:0] v;
    logic [15:0] keep;
    o = '0;
    o.status = wkrt_pkg::ST_OK;
    case (r.mode)
      wkrt_pkg::MODE_ADD: begin
        if (tbl_count >= TABLE_DEPTH) o.status = wkrt_pkg::ST_FULL;
        else begin
          p = place_sorted(tbl_count, r.key_value, r.dest_id);
          tbl_count++;
          o.found_dest = r.dest_id; o.found_key = r.key_value; o.found_slot = 7'(p);
        end
      end
      wkrt_pkg::MODE_REMOVE: begin
        p = find_dest(r.dest_id);
        if (p < 0) o.status = wkrt_pkg::ST_MISS;
        else begin
          o.found_dest = tbl_dest[p]; o.found_key = tbl_key[p]; o.found_slot = 7'(p);
          drop_entry(p);
          tbl_count--;
        end
      end
      wkrt_pkg::MODE_CHANGE: begin
        p = find_dest(r.dest_id);
        if (p < 0) o.status = wkrt_pkg::ST_MISS;
        else begin
          keep = tbl_dest[p];
          drop_entry(p);
          p = place_sorted(tbl_count - 1, r.key_value, keep);
          o.found_dest = keep; o.found_key = r.key_value; o.found_slot = 7'(p);
        end
      end
      wkrt_pkg::MODE_ROUTE: begin
        if (tbl_count == 0 || tbl_key[tbl_count-1] == 0) o.status = wkrt_pkg::ST_EMPTY;
        else begin
          v = r.key_value % tbl_key[tbl_count-1];
          p = tbl_count - 1;
          for (int i = 0; i < tbl_count; i++)
            if (tbl_key[i] > v) begin
              p = i;
              break;
            end
          o.found_dest = tbl_dest[p]; o.found_key = tbl_key[p]; o.found_slot = 7'(p);
        end
      end
      wkrt_pkg::MODE_READ: begin
        if (r.slot_index >= tbl_count) o.status = wkrt_pkg::ST_MISS;
        else begin
          o.found_dest = tbl_dest[r.slot_index];
          o.found_key = tbl_key[r.slot_index];
          o.found_slot = r.slot_index;
        end
      end
      wkrt_pkg::MODE_FIND: begin
        p = find_dest(r.dest_id);
        if (p < 0) o.status = wkrt_pkg::ST_MISS;
        else begin
          o.found_dest = tbl_dest[p]; o.found_key = tbl_key[p]; o.found_slot = 7'(p);
        end
      end
      default: o.status = wkrt_pkg::ST_MISS;
    endcase
    o.entry_total = tbl_count[7:0];
    return o;
  endfunction

  // generator keeps its own id list so remove/change/find mostly hit
  function automatic void push_req(logic [2:0] m, logic [31:0] k, logic [15:0] id,
                                   logic [6:0] s);
    route_req_t r;
    int p;
    r.mode = m; r.key_value = k; r.dest_id = id; r.slot_index = s;
    pending_reqs.push_back(r);
    if (m == wkrt_pkg::MODE_ADD && gen_ids.size() < TABLE_DEPTH) gen_ids.push_back(id);
    if (m == wkrt_pkg::MODE_REMOVE) begin
      p = -1;
      foreach (gen_ids[i])
        if (p < 0 && gen_ids[i] == id) p = i;
      if (p >= 0) gen_ids.delete(p);
    end
  endfunction

  function automatic logic [15:0] some_id();
    if (gen_ids.size() == 0 || $urandom_range(0, 9) == 0)
      return 16'($urandom_range(0, 65535));
    return gen_ids[$urandom_range(0, gen_ids.size() - 1)];
  endfunction

  function automatic logic [31:0] some_key();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15);
      1: return 32'hffff_ffff - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int m;
    // directed: empty table cases first
    push_req(wkrt_pkg::MODE_ROUTE, 32'd5, 16'd0, 7'd0);
    push_req(wkrt_pkg::MODE_READ, 32'd0, 16'd0, 7'd0);
    push_req(wkrt_pkg::MODE_FIND, 32'd0, 16'h1234, 7'd0);
    push_req(wkrt_pkg::MODE_REMOVE, 32'd0, 16'h1234, 7'd0);
    push_req(wkrt_pkg::MODE_CHANGE, 32'd9, 16'h1234, 7'd0);
    push_req(3'd6, 32'hffff_ffff, 16'hffff, 7'h7f);
    push_req(3'd7, 32'd0, 16'd0, 7'd0);
    // zero largest key
    push_req(wkrt_pkg::MODE_ADD, 32'd0, 16'd0, 7'd0);
    push_req(wkrt_pkg::MODE_ROUTE, 32'hffff_ffff, 16'd0, 7'd0);
    push_req(wkrt_pkg::MODE_ADD, 32'hffff_ffff, 16'hffff, 7'h7f);
    push_req(wkrt_pkg::MODE_ADD, 32'd100, 16'h00a5, 7'd0);
    push_req(wkrt_pkg::MODE_ADD, 32'd100, 16'h5a00, 7'd0);  // equal key lands after
    push_req(wkrt_pkg::MODE_ROUTE, 32'hffff_fffe, 16'd0, 7'd0);
    push_req(wkrt_pkg::MODE_ROUTE, 32'd100, 16'd0, 7'd0);
    push_req(wkrt_pkg::MODE_READ, 32'd0, 16'd0, 7'd2);
    push_req(wkrt_pkg::MODE_READ, 32'd0, 16'd0, 7'h7f);
    push_req(wkrt_pkg::MODE_FIND, 32'd0, 16'h5a00, 7'd0);
    push_req(wkrt_pkg::MODE_CHANGE, 32'd1, 16'hffff, 7'd0);
    push_req(wkrt_pkg::MODE_CHANGE, 32'hffff_ffff, 16'd0, 7'd0);
    push_req(wkrt_pkg::MODE_REMOVE, 32'd0, 16'h00a5, 7'd0);
    push_req(wkrt_pkg::MODE_ROUTE, 32'd0, 16'd0, 7'd0);
    // fill to full, add fails, read top slot
    while (gen_ids.size() < TABLE_DEPTH)
      push_req(wkrt_pkg::MODE_ADD, some_key(), 16'($urandom_range(0, 65535)), 7'd0);
    push_req(wkrt_pkg::MODE_ADD, 32'd7, 16'h7777, 7'd0);
    push_req(wkrt_pkg::MODE_READ, 32'd0, 16'd0, 7'h7f);
    push_req(wkrt_pkg::MODE_ROUTE, $urandom, 16'd0, 7'd0);
    // drain mostly, then random mix
    while (gen_ids.size() > 4) push_req(wkrt_pkg::MODE_REMOVE, 32'd0, some_id(), 7'd0);
    for (int n = 0; n < 165; n++) begin
      m = $urandom_range(0, 99);
      if (m < 28)
        push_req(wkrt_pkg::MODE_ADD, some_key(), 16'($urandom_range(0, 65535)), 7'd0);
      else if (m < 40)
        push_req(wkrt_pkg::MODE_REMOVE, $urandom, some_id(), 7'($urandom));
      else if (m < 52)
        push_req(wkrt_pkg::MODE_CHANGE, some_key(), some_id(), 7'($urandom));
      else if (m < 72)
        push_req(wkrt_pkg::MODE_ROUTE, $urandom, 16'($urandom), 7'($urandom));
      else if (m < 84)
        push_req(wkrt_pkg::MODE_READ, $urandom, 16'($urandom),
                 7'($urandom_range(0, gen_ids.size() + 1)));
      else if (m < 96)
        push_req(wkrt_pkg::MODE_FIND, $urandom, some_id(), 7'($urandom));
      else
        push_req(3'($urandom_range(6, 7)), $urandom, 16'($urandom), 7'($urandom));
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_gap <= 0;
      tbl_count = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid && in_tready) expected_rsps.push_back(predict_route(pending_reqs.pop_front()));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (in_tvalid && in_tready && !calm && $urandom_range(0, 3) == 0) begin
        in_gap <= $urandom_range(0, 7);
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= pack_req(pending_reqs[0]);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    calm <= pending_reqs.size() < 60;
    stim_done <= pending_reqs.size() == 0 && !in_tvalid;
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    route_rsp_t got;
    route_rsp_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
      errors <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = unpack_rsp(out_tdata);
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_tdata);
          errors <= errors + 1;
        end else begin
          want = expected_rsps.pop_front();
          if (got.status != want.status || got.found_dest != want.found_dest ||
              got.found_key != want.found_key || got.found_slot != want.found_slot ||
              got.entry_total != want.entry_total) begin
            $display("%0t: mismatch expected st=%0d dest=%h key=%h slot=%0d total=%0d",
                     $time, want.status, want.found_dest, want.found_key,
                     want.found_slot, want.entry_total);
            $display("%0t:          actual   st=%0d dest=%h key=%h slot=%0d total=%0d",
                     $time, got.status, got.found_dest, got.found_key,
                     got.found_slot, got.entry_total);
            errors <= errors + 1;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (rst_n === 1'b1);
    while (!(stim_done && expected_rsps.size() == 0) && idle_cycles < STALL_LIMIT)
      @(posedge clk);
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
    end else begin
      repeat (600) @(posedge clk);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/wkrt_pkg.sv
src/wkrt_ctrl.sv
src/wkrt_datapath.sv
src/weighted_key_route_table_core.sv
dv/weighted_key_route_table_core_test.sv
